// ===== hw/rtl/tq_pkg.sv =====
// tq_pkg: shared types and codes for the timer expiry queue.
// Used by tq_cell and timer_expiry_queue; no dependencies.
package tq_pkg;

    localparam int ID_W    = 8;
    localparam int IVL_W   = 32;
    localparam int MIN_W   = 20;
    localparam int PORT_TW = 48;
    localparam int KIND_W  = 2;

    localparam logic [MIN_W-1:0] MIN_DELAY_RST = 20'd100;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // take the right neighbor's entry (pop the head)
        logic insert;  // sorted insert of the broadcast entry
        logic mark;    // flag entries due at the current time
    } tq_cmd_t;

endpackage

// ===== hw/rtl/timer_expiry_queue.sv =====
// timer_expiry_queue: top level, sequencer plus a sorted chain of tq_cell.
// Depends on tq_pkg and tq_cell.
//
// Timers live in a chain of TABLE_DEPTH cells kept sorted by (expiry, id), so
// the head cell always holds the next expiry. An add goes from acceptance to its
// acknowledge through one sorted insert into the chain and one status step. A
// tick marks the due entries, pops each fired one-shot timer from the head and
// pops and sorted re-inserts each fired repeating timer, then gives the status;
// stalls on the result channel can hold the pop and status steps. One item is in
// work at a time; the result register lets the final result wait while the next
// item is accepted.
module timer_expiry_queue #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [tq_pkg::ID_W-1:0]      timer_id,
    input  logic [tq_pkg::PORT_TW-1:0]   expiry_time,
    input  logic [tq_pkg::IVL_W-1:0]     repeat_interval,
    input  logic [tq_pkg::PORT_TW-1:0]   current_time,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tq_pkg::KIND_W-1:0]    result_kind,
    output logic [tq_pkg::ID_W-1:0]      fired_id,
    output logic                         earliest_changed,
    output logic [tq_pkg::PORT_TW-1:0]   next_expiry,
    output logic [tq_pkg::PORT_TW-1:0]   arm_delay,
    output logic                         queue_empty,
    output logic                         table_full,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tq_pkg::MIN_W-1:0]     cfg_data
);
    import tq_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int D  = TABLE_DEPTH;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_MARK, S_POP, S_REINS, S_STATUS
    } state_t;

    state_t            state_reg;
    logic              op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TW-1:0]     exp_reg;
    logic [IVL_W-1:0]  ivl_reg;
    logic [TW-1:0]     now_reg;
    logic              chg_reg;
    logic              full_reg;
    logic [MIN_W-1:0]  min_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   fid_reg;
    logic              ochg_reg;
    logic [TW-1:0]     onext_reg;
    logic [TW-1:0]     odelay_reg;
    logic              oempty_reg;
    logic              ofull_reg;
    logic              olast_reg;

    // Chain wiring, index D is the empty end
    logic              c_valid  [D+1];
    logic              c_due    [D+1];
    logic [TW-1:0]     c_exp    [D+1];
    logic [ID_W-1:0]   c_id     [D+1];
    logic [IVL_W-1:0]  c_ivl    [D+1];
    logic              c_ahead  [D];
    logic [D-1:0]      vld_vec;
    tq_cmd_t           cmd;

    assign c_valid[D] = 1'b0;
    assign c_due[D]   = 1'b0;
    assign c_exp[D]   = '0;
    assign c_id[D]    = '0;
    assign c_ivl[D]   = '0;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        tq_cell #(.TW(TW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .now         (now_reg),
            .ins_exp     (exp_reg),
            .ins_id      (id_reg),
            .ins_ivl     (ivl_reg),
            .left_valid  ((i == 0) ? 1'b0 : c_valid[(i == 0) ? 0 : i-1]),
            .left_due    (c_due[(i == 0) ? 0 : i-1]),
            .left_exp    (c_exp[(i == 0) ? 0 : i-1]),
            .left_id     (c_id[(i == 0) ? 0 : i-1]),
            .left_ivl    (c_ivl[(i == 0) ? 0 : i-1]),
            .left_ahead  ((i == 0) ? 1'b0 : c_ahead[(i == 0) ? 0 : i-1]),
            .right_valid (c_valid[i+1]),
            .right_due   (c_due[i+1]),
            .right_exp   (c_exp[i+1]),
            .right_id    (c_id[i+1]),
            .right_ivl   (c_ivl[i+1]),
            .valid       (c_valid[i]),
            .due         (c_due[i]),
            .exp         (c_exp[i]),
            .id          (c_id[i]),
            .ivl         (c_ivl[i]),
            .ahead       (c_ahead[i])
        );
        assign vld_vec[i] = c_valid[i];
    end

    // Head status and arm delay
    logic          out_free;
    logic [TW-1:0] diff;
    logic [TW-1:0] min_tw;
    logic [TW-1:0] delay;
    logic [TW:0]   resum;
    logic [TW-1:0] reexp;

    assign out_free = !out_valid_reg || !out_stall;
    assign diff     = c_exp[0] - now_reg;
    assign min_tw   = TW'(min_reg);
    assign delay    = ((c_exp[0] > now_reg) && (diff > min_tw)) ? diff : min_tw;
    assign resum    = {1'b0, now_reg} + (TW+1)'(c_ivl[0]);
    assign reexp    = resum[TW] ? '1 : resum[TW-1:0];

    // Chain commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_ADD:   cmd.insert = !c_valid[D-1];
            S_MARK:  cmd.mark = 1'b1;
            S_POP:   cmd.shift = c_valid[0] && c_due[0] && out_free;
            S_REINS: cmd.insert = 1'b1;
            default: cmd = '0;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ADD;
            id_reg        <= '0;
            exp_reg       <= '0;
            ivl_reg       <= '0;
            now_reg       <= '0;
            chg_reg       <= 1'b0;
            full_reg      <= 1'b0;
            min_reg       <= MIN_DELAY_RST;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_ADD;
            fid_reg       <= '0;
            ochg_reg      <= 1'b0;
            onext_reg     <= '0;
            odelay_reg    <= '0;
            oempty_reg    <= 1'b0;
            ofull_reg     <= 1'b0;
            olast_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
            if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= operation;
                        id_reg   <= timer_id;
                        exp_reg  <= TW'(expiry_time);
                        ivl_reg  <= repeat_interval;
                        now_reg  <= TW'(current_time);
                        chg_reg  <= 1'b0;
                        full_reg <= 1'b0;
                        state_reg <= (operation == OP_TICK) ? S_MARK : S_ADD;
                    end
                end
                S_ADD:
                begin
                    full_reg  <= c_valid[D-1];
                    chg_reg   <= !c_valid[D-1] && (!c_valid[0] || (exp_reg < c_exp[0]));
                    state_reg <= S_STATUS;
                end
                S_MARK:
                begin
                    state_reg <= S_POP;
                end
                S_POP:
                begin
                    if (c_valid[0] && c_due[0])
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= KIND_FIRED;
                            fid_reg       <= c_id[0];
                            ochg_reg      <= 1'b0;
                            onext_reg     <= '0;
                            odelay_reg    <= '0;
                            oempty_reg    <= 1'b0;
                            ofull_reg     <= 1'b0;
                            olast_reg     <= 1'b0;
                            exp_reg       <= reexp;
                            id_reg        <= c_id[0];
                            ivl_reg       <= c_ivl[0];
                            if (c_ivl[0] != '0)
                            begin
                                state_reg <= S_REINS;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= S_STATUS;
                    end
                end
                S_REINS:
                begin
                    state_reg <= S_POP;
                end
                S_STATUS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= (op_reg == OP_TICK) ? KIND_TICK : KIND_ADD;
                        fid_reg       <= '0;
                        ochg_reg      <= chg_reg;
                        onext_reg     <= c_valid[0] ? c_exp[0] : '0;
                        odelay_reg    <= c_valid[0] ? delay : '0;
                        oempty_reg    <= !c_valid[0];
                        ofull_reg     <= full_reg;
                        olast_reg     <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = kind_reg;
    assign fired_id         = fid_reg;
    assign earliest_changed = ochg_reg;
    assign next_expiry      = PORT_TW'(onext_reg);
    assign arm_delay        = PORT_TW'(odelay_reg);
    assign queue_empty      = oempty_reg;
    assign table_full       = ofull_reg;
    assign last             = olast_reg;

    // Occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec + D'(1)) & vld_vec) == '0)
        else $error("chain has a hole");

    // Re-insert only happens with room at the tail
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REINS) |-> !c_valid[D-1])
        else $error("re-insert into full chain");

    // A fired result never closes an item
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_FIRED)) |-> !last)
        else $error("fired result marked last");

    // Due flags only live inside a tick
    a_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(c_valid[0] && c_due[0]))
        else $error("due entry left after tick");

endmodule

// ===== hw/rtl/tq_cell.sv =====
// tq_cell: one entry of the sorted timer chain.
// Depends on tq_pkg for the command struct and field widths.
module tq_cell #(
    parameter int TW = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tq_pkg::tq_cmd_t       cmd,
    input  logic [TW-1:0]         now,
    input  logic [TW-1:0]         ins_exp,
    input  logic [tq_pkg::ID_W-1:0]  ins_id,
    input  logic [tq_pkg::IVL_W-1:0] ins_ivl,
    input  logic                  left_valid,
    input  logic                  left_due,
    input  logic [TW-1:0]         left_exp,
    input  logic [tq_pkg::ID_W-1:0]  left_id,
    input  logic [tq_pkg::IVL_W-1:0] left_ivl,
    input  logic                  left_ahead,
    input  logic                  right_valid,
    input  logic                  right_due,
    input  logic [TW-1:0]         right_exp,
    input  logic [tq_pkg::ID_W-1:0]  right_id,
    input  logic [tq_pkg::IVL_W-1:0] right_ivl,
    output logic                  valid,
    output logic                  due,
    output logic [TW-1:0]         exp,
    output logic [tq_pkg::ID_W-1:0]  id,
    output logic [tq_pkg::IVL_W-1:0] ivl,
    output logic                  ahead
);
    import tq_pkg::*;

    logic              valid_reg, valid_next;
    logic              due_reg, due_next;
    logic [TW-1:0]     exp_reg, exp_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [IVL_W-1:0]  ivl_reg, ivl_next;

    // New entry sorts ahead of this one: key is {not due, expiry, id}
    assign ahead = !valid_reg ||
                   ({~due_reg, exp_reg, id_reg} > {1'b1, ins_exp, ins_id});

    always_comb
    begin
        valid_next = valid_reg;
        due_next   = due_reg;
        exp_next   = exp_reg;
        id_next    = id_reg;
        ivl_next   = ivl_reg;
        if (cmd.shift)
        begin
            valid_next = right_valid;
            due_next   = right_due;
            exp_next   = right_exp;
            id_next    = right_id;
            ivl_next   = right_ivl;
        end
        else if (cmd.insert && ahead)
        begin
            if (left_ahead)
            begin
                valid_next = left_valid;
                due_next   = left_due;
                exp_next   = left_exp;
                id_next    = left_id;
                ivl_next   = left_ivl;
            end
            else
            begin
                valid_next = 1'b1;
                due_next   = 1'b0;
                exp_next   = ins_exp;
                id_next    = ins_id;
                ivl_next   = ins_ivl;
            end
        end
        else if (cmd.mark)
        begin
            due_next = valid_reg && (exp_reg <= now);
        end
    end

    // Control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            due_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            due_reg   <= due_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        id_reg  <= id_next;
        ivl_reg <= ivl_next;
    end

    assign valid = valid_reg;
    assign due   = due_reg;
    assign exp   = exp_reg;
    assign id    = id_reg;
    assign ivl   = ivl_reg;

endmodule
